FILE: rtl/sls_pkg.sv
// Shared constants and types for the sync/length/checksum frame checker.
`timescale 1ns / 1ps

package sls_pkg;

    // Default counter wrap depth in bytes.
    localparam int BufferDepthDefault = 1024;

    // The two sync bytes that open every frame.
    localparam logic [7:0] SyncFirst  = 8'h55;
    localparam logic [7:0] SyncSecond = 8'hAA;

    localparam int StatusWidth   = 3;
    localparam int PositionWidth = 10;
    localparam int ByteWidth     = 8;

    // Per-byte status code.
    typedef enum logic [StatusWidth-1:0] {
        ST_COLLECT  = 3'd0,
        ST_GOOD     = 3'd1,
        ST_CSUM_ERR = 3'd2,
        ST_SYNC_ERR = 3'd3,
        ST_WRAP     = 3'd4
    } t_status;

endpackage

FILE: rtl/sync_length_sum_frame_checker.sv
// Top level of the sync/length/checksum frame checker.
`timescale 1ns / 1ps

// Each result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the frame state (byte counter, length byte,
// running sum) is updated in the cycle the word is accepted, so the next word
// can follow at once, unless the single output register is stalled.
// Reset: synchronous, active low; clears the counter, length and sum to zero
// and empties the output register.
module sync_length_sum_frame_checker #(
    parameter int BUFFER_DEPTH = sls_pkg::BufferDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [9:0] byte_position, [17:10] byte_echo, rest zero
    output logic [2:0]  o_m_axis_tuser    // [2:0] status
);

    // The counter only ever holds values below the depth.
    localparam int CW = $clog2(BUFFER_DEPTH);
    localparam int PW = sls_pkg::PositionWidth;
    localparam int BW = sls_pkg::ByteWidth;

    // Frame state.
    logic [CW-1:0] r_count, n_count;
    logic [BW-1:0] r_length, n_length;
    logic [BW-1:0] r_sum, n_sum;

    // Output register.
    logic                   r_out_valid;
    sls_pkg::t_status       r_status, n_status;
    logic [PW-1:0]          r_position;
    logic [BW-1:0]          r_echo;

    logic          w_accept;
    logic [CW:0]   w_next;
    logic [BW-1:0] w_byte;

    // A word can enter whenever the output register is empty or being drained.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_byte          = i_s_axis_tdata;

    // Count after this byte, one bit wider so the depth itself can be seen.
    assign w_next = {1'b0, r_count} + (CW+1)'(1);

    // Frame decision for the byte at the input. The order of the checks matters: a
    // wrap overrides everything, then the sync bytes, then the length capture, then
    // the length-against-depth check, then the end-of-frame compare, and only then the sum.
    always_comb begin
        n_count  = w_next[CW-1:0];
        n_length = r_length;
        n_sum    = r_sum;
        n_status = sls_pkg::ST_COLLECT;

        if (w_next >= (CW+1)'(BUFFER_DEPTH)) begin
            n_count  = '0;
            n_status = sls_pkg::ST_WRAP;
        end else if (r_count == CW'(0)) begin
            if (w_byte != sls_pkg::SyncFirst) begin
                n_count  = '0;
                n_status = sls_pkg::ST_SYNC_ERR;
            end
        end else if (r_count == CW'(1)) begin
            if (w_byte != sls_pkg::SyncSecond) begin
                n_count  = '0;
                n_status = sls_pkg::ST_SYNC_ERR;
            end
        end else if (r_count == CW'(2)) begin
            n_length = w_byte;
        end else if (32'(r_length) >= 32'(BUFFER_DEPTH)) begin
            // Only reachable with a depth below 256.
            n_count  = '0;
            n_status = sls_pkg::ST_SYNC_ERR;
        end else if (w_next == (CW+1)'(r_length)) begin
            // Last byte of the frame: it must equal the sum of all before it.
            // A length of four lands here before the sum has been seeded.
            n_status = (r_sum == w_byte) ? sls_pkg::ST_GOOD : sls_pkg::ST_CSUM_ERR;
            n_count  = '0;
        end else if (w_next == (CW+1)'(4)) begin
            // Seed the sum with the header bytes and this byte.
            n_sum = sls_pkg::SyncFirst + sls_pkg::SyncSecond + r_length + w_byte;
        end else begin
            n_sum = r_sum + w_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_length    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_length    <= n_length;
                r_sum       <= n_sum;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register; it needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_position <= PW'(r_count);
            r_echo     <= w_byte;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_echo, r_position};
    assign o_m_axis_tuser  = r_status;

endmodule

FILE: rtl/sls_checker.sv
// Port-level assertions for the frame checker and their bind statement.
`timescale 1ns / 1ps

module sls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    logic w_s_acc;
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result word changed");

    // Every accepted word shows up at the output on the next cycle, echoed.
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> o_m_axis_tvalid && o_m_axis_tdata[17:10] == $past(i_s_axis_tdata))
        else $error("accepted word not echoed one cycle later");

    // Reset empties the output.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // The first byte of a frame is either collected or rejected as a sync error.
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[9:0] == 10'd0 |->
            o_m_axis_tuser == sls_pkg::ST_COLLECT || o_m_axis_tuser == sls_pkg::ST_SYNC_ERR)
        else $error("bad status at frame start");

    // A frame can only end on a checksum compare from position three on.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid &&
        (o_m_axis_tuser == sls_pkg::ST_GOOD || o_m_axis_tuser == sls_pkg::ST_CSUM_ERR) |->
            o_m_axis_tdata[9:0] >= 10'd3)
        else $error("checksum result before position three");

endmodule

bind sync_length_sum_frame_checker sls_checker u_sls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
